// ===== hw/rtl/slogev_pkg.sv =====
// ----------------------------------------------------------------------------
// slogev_pkg
// Shared types and constants of the Slater orbital grid evaluator.
// ----------------------------------------------------------------------------
package slogev_pkg;

    localparam int MAX_ATOMS = 64;
    localparam int MAX_BASIS = 64;
    localparam int FRAC_BITS = 16;
    localparam int ATOM_AW   = $clog2(MAX_ATOMS);
    localparam int BASIS_AW  = $clog2(MAX_BASIS);

    localparam logic [1:0] REQ_ATOM  = 2'd0;
    localparam logic [1:0] REQ_BASIS = 2'd1;
    localparam logic [1:0] REQ_EVAL  = 2'd2;
    localparam logic [1:0] REQ_NOP   = 2'd3;

    localparam logic [2:0] KIND_S  = 3'd0;
    localparam logic [2:0] KIND_PX = 3'd1;
    localparam logic [2:0] KIND_PY = 3'd2;
    localparam logic [2:0] KIND_PZ = 3'd3;

    localparam logic [30:0] Q30_ONE   = 31'h4000_0000;
    localparam logic [30:0] LOG2E_Q30 = 31'd1549082005;
    localparam logic [29:0] LN2_Q30   = 30'd744261118;
    localparam logic [52:0] TERM_LIM  = 53'h10_0000_0000_0000;

    // ceil(2^35 / i): exact quotient for dividends below 2^31
    localparam logic [35:0] RECIP_Q35 [1:10] = '{
        36'd34359738368, 36'd17179869184, 36'd11453246123, 36'd8589934592,
        36'd6871947674,  36'd5726623062,  36'd4908534053,  36'd4294967296,
        36'd3817748708,  36'd3435973837
    };

    typedef struct packed {
        logic [1:0]         req_type;
        logic [5:0]         entry_index;
        logic signed [31:0] coord_x;
        logic signed [31:0] coord_y;
        logic signed [31:0] coord_z;
        logic signed [31:0] coefficient;
        logic [23:0]        exponent;
        logic [2:0]         orbital_kind;
        logic [2:0]         principal_number;
        logic [5:0]         centre_atom;
    } slogev_req_t;

    typedef struct packed {
        logic signed [31:0] orbital_value;
        logic               is_value;
        logic               saturated;
    } slogev_rsp_t;

    typedef struct packed {
        logic        first;
        logic        last;
        logic        skip;
        logic [2:0]  kind;
        logic [2:0]  pw;
        logic        neg;
        logic [31:0] coef_mag;
        logic [23:0] zeta;
        logic [32:0] comp_mag;
        logic [32:0] dm0;
        logic [32:0] dm1;
        logic [32:0] dm2;
        logic [64:0] sq0;
        logic [64:0] sq1;
        logic [64:0] sq2;
        logic [65:0] rad;
        logic [32:0] root;
        logic [36:0] rem;
        logic        zero;
        logic [21:0] t;
        logic [6:0]  k;
        logic [15:0] fr;
        logic [29:0] g;
        logic [30:0] p;
        logic [30:0] x;
        logic [52:0] m;
        logic [58:0] plo;
        logic [59:0] phi;
        logic        clip;
    } slogev_lane_t;

endpackage

// ===== hw/rtl/slogev_ram.sv =====
// ----------------------------------------------------------------------------
// slogev_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module slogev_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                                   clk,
    input  logic                                   wen,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wen)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== hw/rtl/slogev_term.sv =====
// ----------------------------------------------------------------------------
// slogev_term
// Pipelined term unit: one basis term per cycle, distance, root, exponential,
// radial powers and angular factor, signed term out.
// ----------------------------------------------------------------------------
module slogev_term import slogev_pkg::*; (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_first,
    input  logic               in_last,
    input  logic [31:0]        coef,
    input  logic [23:0]        zeta,
    input  logic [11:0]        shape,
    input  logic [31:0]        ax,
    input  logic [31:0]        ay,
    input  logic [31:0]        az,
    input  logic [31:0]        px,
    input  logic [31:0]        py,
    input  logic [31:0]        pz,
    output logic               out_valid,
    output logic               out_first,
    output logic               out_last,
    output logic signed [53:0] term,
    output logic               clip
);

    localparam int R_BASE = 3;
    localparam int Z_BASE = R_BASE + 33;
    localparam int P_BASE = Z_BASE + 3;
    localparam int X_BASE = P_BASE + 20;
    localparam int S_BASE = X_BASE + 2;
    localparam int NST    = S_BASE + 14;

    slogev_lane_t st_reg  [NST];
    slogev_lane_t st_next [NST];
    logic         vld_reg [NST];

    logic               fvld_reg;
    logic               ffirst_reg;
    logic               flast_reg;
    logic               fclip_reg;
    logic signed [53:0] term_reg;

    always_comb
    begin
        logic [32:0]  dx;
        logic [32:0]  dy;
        logic [32:0]  dz;
        logic [2:0]   kd;
        logic [2:0]   nn;
        logic [32:0]  cm;
        logic         cn;
        logic [36:0]  rw;
        logic [36:0]  trial;
        logic [56:0]  zp;
        logic [52:0]  yp;
        logic [59:0]  fp;
        logic [60:0]  pr;
        logic [66:0]  qq;
        logic [62:0]  mp;
        logic [32:0]  op;
        logic [85:0]  full;
        logic [69:0]  sh;
        logic         en;
        int           i;

        dx = {px[31], px} - {ax[31], ax};
        dy = {py[31], py} - {ay[31], ay};
        dz = {pz[31], pz} - {az[31], az};
        kd = shape[2:0];
        nn = shape[5:3];
        st_next[0] = '0;
        st_next[0].first = in_first;
        st_next[0].last  = in_last;
        st_next[0].kind  = kd;
        st_next[0].skip  = (kd > KIND_PZ);
        st_next[0].zeta  = zeta;
        st_next[0].coef_mag = coef[31] ? (~coef + 32'd1) : coef;
        st_next[0].dm0 = dx[32] ? (~dx + 33'd1) : dx;
        st_next[0].dm1 = dy[32] ? (~dy + 33'd1) : dy;
        st_next[0].dm2 = dz[32] ? (~dz + 33'd1) : dz;
        case (kd)
            KIND_PX:
            begin
                cm = st_next[0].dm0;
                cn = dx[32];
            end
            KIND_PY:
            begin
                cm = st_next[0].dm1;
                cn = dy[32];
            end
            KIND_PZ:
            begin
                cm = st_next[0].dm2;
                cn = dz[32];
            end
            default:
            begin
                cm = '0;
                cn = 1'b0;
            end
        endcase
        st_next[0].comp_mag = cm;
        st_next[0].neg      = coef[31] ^ cn;
        if (kd == KIND_S)
        begin
            st_next[0].pw = (nn == 3'd0) ? 3'd0 : nn - 3'd1;
        end
        else
        begin
            st_next[0].pw = (nn < 3'd2) ? 3'd0 : nn - 3'd2;
        end

        // squares
        st_next[1]     = st_reg[0];
        st_next[1].sq0 = 65'(st_reg[0].dm0 * st_reg[0].dm0);
        st_next[1].sq1 = 65'(st_reg[0].dm1 * st_reg[0].dm1);
        st_next[1].sq2 = 65'(st_reg[0].dm2 * st_reg[0].dm2);

        st_next[2]      = st_reg[1];
        st_next[2].rad  = 66'(st_reg[1].sq0) + 66'(st_reg[1].sq1) + 66'(st_reg[1].sq2);
        st_next[2].root = '0;
        st_next[2].rem  = '0;

        // integer square root, one bit pair per stage
        for (int j = 0; j < 33; j++)
        begin
            i = 32 - j;
            st_next[R_BASE + j] = st_reg[R_BASE + j - 1];
            rw    = {st_reg[R_BASE + j - 1].rem[34:0], st_reg[R_BASE + j - 1].rad[2 * i +: 2]};
            trial = {2'b00, st_reg[R_BASE + j - 1].root, 2'b01};
            if (rw >= trial)
            begin
                st_next[R_BASE + j].rem  = rw - trial;
                st_next[R_BASE + j].root = {st_reg[R_BASE + j - 1].root[31:0], 1'b1};
            end
            else
            begin
                st_next[R_BASE + j].rem  = rw;
                st_next[R_BASE + j].root = {st_reg[R_BASE + j - 1].root[31:0], 1'b0};
            end
        end

        zp = 57'(st_reg[Z_BASE - 1].zeta * st_reg[Z_BASE - 1].root);
        st_next[Z_BASE]      = st_reg[Z_BASE - 1];
        st_next[Z_BASE].zero = (zp[56:FRAC_BITS + 22 - 16 + 16] != '0);
        st_next[Z_BASE].t    = zp[FRAC_BITS +: 22];

        yp = 53'(st_reg[Z_BASE].t * LOG2E_Q30);
        st_next[Z_BASE + 1]      = st_reg[Z_BASE];
        st_next[Z_BASE + 1].k    = yp[52:46];
        st_next[Z_BASE + 1].fr   = yp[45:30];
        st_next[Z_BASE + 1].zero = st_reg[Z_BASE].zero || (yp[52:46] >= 7'd30);

        fp = 60'({st_reg[Z_BASE + 1].fr, 14'd0} * LN2_Q30);
        st_next[Z_BASE + 2]   = st_reg[Z_BASE + 1];
        st_next[Z_BASE + 2].g = fp[59:30];
        st_next[Z_BASE + 2].p = Q30_ONE;

        // series for 2^-f, two stages per term
        for (int q = 0; q < 10; q++)
        begin
            pr = 61'(st_reg[P_BASE + 2 * q - 1].g * st_reg[P_BASE + 2 * q - 1].p);
            st_next[P_BASE + 2 * q]   = st_reg[P_BASE + 2 * q - 1];
            st_next[P_BASE + 2 * q].x = pr[60:30];
            qq = 67'(st_reg[P_BASE + 2 * q].x * RECIP_Q35[10 - q]);
            st_next[P_BASE + 2 * q + 1]   = st_reg[P_BASE + 2 * q];
            st_next[P_BASE + 2 * q + 1].p = Q30_ONE - qq[65:35];
        end

        st_next[X_BASE]   = st_reg[X_BASE - 1];
        st_next[X_BASE].p = st_reg[X_BASE - 1].zero ? '0 :
                            (st_reg[X_BASE - 1].p >> st_reg[X_BASE - 1].k);

        mp = 63'(st_reg[X_BASE].coef_mag * st_reg[X_BASE].p);
        st_next[X_BASE + 1]      = st_reg[X_BASE];
        st_next[X_BASE + 1].m    = {20'd0, mp[62:30]};
        st_next[X_BASE + 1].clip = 1'b0;

        // radial powers then the angular factor, split products
        for (int j = 0; j < 7; j++)
        begin
            op = (j < 6) ? st_reg[S_BASE + 2 * j - 1].root : st_reg[S_BASE + 2 * j - 1].comp_mag;
            st_next[S_BASE + 2 * j]     = st_reg[S_BASE + 2 * j - 1];
            st_next[S_BASE + 2 * j].plo = 59'(st_reg[S_BASE + 2 * j - 1].m[25:0] * op);
            st_next[S_BASE + 2 * j].phi = 60'(st_reg[S_BASE + 2 * j - 1].m[52:26] * op);
            full = {st_reg[S_BASE + 2 * j].phi, 26'd0} + 86'(st_reg[S_BASE + 2 * j].plo);
            sh   = full[85:FRAC_BITS];
            en   = (j < 6) ? (3'(j) < st_reg[S_BASE + 2 * j].pw)
                           : (st_reg[S_BASE + 2 * j].kind != KIND_S);
            st_next[S_BASE + 2 * j + 1] = st_reg[S_BASE + 2 * j];
            if (en)
            begin
                if (sh > 70'(TERM_LIM))
                begin
                    st_next[S_BASE + 2 * j + 1].m    = TERM_LIM;
                    st_next[S_BASE + 2 * j + 1].clip = 1'b1;
                end
                else
                begin
                    st_next[S_BASE + 2 * j + 1].m = sh[52:0];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < NST; s++)
            begin
                vld_reg[s] <= 1'b0;
            end
            fvld_reg <= 1'b0;
        end
        else
        begin
            vld_reg[0] <= in_valid;
            for (int s = 1; s < NST; s++)
            begin
                vld_reg[s] <= vld_reg[s - 1];
            end
            fvld_reg <= vld_reg[NST - 1];
        end
    end

    always_ff @(posedge clk)
    begin
        for (int s = 0; s < NST; s++)
        begin
            st_reg[s] <= st_next[s];
        end
        ffirst_reg <= st_reg[NST - 1].first;
        flast_reg  <= st_reg[NST - 1].last;
        fclip_reg  <= st_reg[NST - 1].clip && !st_reg[NST - 1].skip;
        if (st_reg[NST - 1].skip)
        begin
            term_reg <= '0;
        end
        else if (st_reg[NST - 1].neg)
        begin
            term_reg <= -$signed({1'b0, st_reg[NST - 1].m});
        end
        else
        begin
            term_reg <= $signed({1'b0, st_reg[NST - 1].m});
        end
    end

    assign out_valid = fvld_reg;
    assign out_first = ffirst_reg;
    assign out_last  = flast_reg;
    assign term      = term_reg;
    assign clip      = fclip_reg;

endmodule

// ===== hw/rtl/slater_orbital_grid_evaluator_unit.sv =====
// ----------------------------------------------------------------------------
// slater_orbital_grid_evaluator_unit
// Atom and basis tables with a pipelined Slater orbital term unit.
// ----------------------------------------------------------------------------
// A load, an unknown request and an evaluation with a zero basis count are
// acknowledged on done in the next cycle, and busy stays low. Any other
// evaluation holds busy high while the basis table issues one term per cycle
// for N entries, N being basis_count clamped to 64, and while two table reads
// and a 76-stage term unit follow; the result shows on done for one cycle,
// the first cycle in which busy is low again. The receiver cannot stall;
// every result must be taken in the cycle it is shown.
// ----------------------------------------------------------------------------
module slater_orbital_grid_evaluator_unit import slogev_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  slogev_req_t request,
    input  logic        cfg_wen,
    input  logic [6:0]  cfg_wdata,
    output logic        done,
    output slogev_rsp_t result
);

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_ISSUE = 3'b010,
        ST_DRAIN = 3'b100
    } state_t;

    state_t             state_reg;
    logic [6:0]         count_reg;
    logic [6:0]         cnt_reg;
    logic [6:0]         idx_reg;
    logic [31:0]        px_reg;
    logic [31:0]        py_reg;
    logic [31:0]        pz_reg;
    logic               v1_reg;
    logic               f1_reg;
    logic               l1_reg;
    logic               v2_reg;
    logic               f2_reg;
    logic               l2_reg;
    logic [67:0]        bdat_reg;
    logic signed [59:0] acc_reg;
    logic               aclip_reg;
    logic               done_reg;
    slogev_rsp_t        result_reg;

    logic               accept;
    logic               issue;
    logic [6:0]         cnt_clamp;
    logic [67:0]        brdata;
    logic [95:0]        ardata;
    logic               t_vld;
    logic               t_first;
    logic               t_last;
    logic signed [53:0] t_term;
    logic               t_clip;
    logic signed [59:0] sum;
    logic               sum_clip;
    logic signed [31:0] sum_value;
    logic               sum_sat;

    assign busy      = (state_reg != ST_IDLE);
    assign accept    = start && !busy;
    assign issue     = (state_reg == ST_ISSUE);
    assign cnt_clamp = (count_reg > 7'(MAX_BASIS)) ? 7'(MAX_BASIS) : count_reg;

    slogev_ram #(.WIDTH(68), .DEPTH(MAX_BASIS)) u_basis (
        .clk   (clk),
        .wen   (accept && (request.req_type == REQ_BASIS)),
        .waddr (request.entry_index[BASIS_AW-1:0]),
        .wdata ({request.centre_atom, request.principal_number, request.orbital_kind,
                 request.exponent, request.coefficient}),
        .raddr (idx_reg[BASIS_AW-1:0]),
        .rdata (brdata)
    );

    slogev_ram #(.WIDTH(96), .DEPTH(MAX_ATOMS)) u_atom (
        .clk   (clk),
        .wen   (accept && (request.req_type == REQ_ATOM)),
        .waddr (request.entry_index[ATOM_AW-1:0]),
        .wdata ({request.coord_z, request.coord_y, request.coord_x}),
        .raddr (brdata[62 +: ATOM_AW]),
        .rdata (ardata)
    );

    slogev_term u_term (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v2_reg),
        .in_first  (f2_reg),
        .in_last   (l2_reg),
        .coef      (bdat_reg[31:0]),
        .zeta      (bdat_reg[55:32]),
        .shape     (bdat_reg[67:56]),
        .ax        (ardata[31:0]),
        .ay        (ardata[63:32]),
        .az        (ardata[95:64]),
        .px        (px_reg),
        .py        (py_reg),
        .pz        (pz_reg),
        .out_valid (t_vld),
        .out_first (t_first),
        .out_last  (t_last),
        .term      (t_term),
        .clip      (t_clip)
    );

    assign sum      = (t_first ? 60'sd0 : acc_reg) + {{6{t_term[53]}}, t_term};
    assign sum_clip = (t_first ? 1'b0 : aclip_reg) || t_clip;

    always_comb
    begin
        if (sum > 60'sh7FFF_FFFF)
        begin
            sum_value = 32'sh7FFF_FFFF;
            sum_sat   = 1'b1;
        end
        else if (sum < -60'sh8000_0000)
        begin
            sum_value = 32'sh8000_0000;
            sum_sat   = 1'b1;
        end
        else
        begin
            sum_value = sum[31:0];
            sum_sat   = sum_clip;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            idx_reg   <= '0;
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            v1_reg   <= issue;
            v2_reg   <= v1_reg;
            done_reg <= 1'b0;
            if (cfg_wen)
            begin
                count_reg <= cfg_wdata;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        idx_reg <= '0;
                        if ((request.req_type == REQ_EVAL) && (cnt_clamp != 7'd0))
                        begin
                            state_reg <= ST_ISSUE;
                        end
                        else
                        begin
                            done_reg <= 1'b1;
                        end
                    end
                end
                ST_ISSUE:
                begin
                    idx_reg <= idx_reg + 7'd1;
                    if (idx_reg == cnt_reg - 7'd1)
                    begin
                        state_reg <= ST_DRAIN;
                    end
                end
                ST_DRAIN:
                begin
                    if (t_vld && t_last)
                    begin
                        state_reg <= ST_IDLE;
                        done_reg  <= 1'b1;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        f1_reg   <= (idx_reg == 7'd0);
        l1_reg   <= (idx_reg == cnt_reg - 7'd1);
        f2_reg   <= f1_reg;
        l2_reg   <= l1_reg;
        bdat_reg <= brdata;
        if (accept)
        begin
            cnt_reg    <= cnt_clamp;
            px_reg     <= request.coord_x;
            py_reg     <= request.coord_y;
            pz_reg     <= request.coord_z;
            result_reg <= '{orbital_value: 32'sd0,
                            is_value: (request.req_type == REQ_EVAL),
                            saturated: 1'b0};
        end
        if (t_vld)
        begin
            acc_reg   <= sum;
            aclip_reg <= sum_clip;
            if (t_last)
            begin
                result_reg <= '{orbital_value: sum_value, is_value: 1'b1, saturated: sum_sat};
            end
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

    a_idle_no_terms: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> (!t_vld && !v1_reg && !v2_reg))
        else $error("term in flight while idle");

    a_issue_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ISSUE) |-> (idx_reg < cnt_reg))
        else $error("issue index beyond basis count");

    a_last_in_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (t_vld && t_last) |-> (state_reg == ST_DRAIN))
        else $error("last term outside drain");

endmodule

// ===== sim/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Testbench of the Slater orbital grid evaluator: loads the atom and basis
// tables, evaluates points under several basis counts, and checks every
// transfer on the result port against an in-bench fixed-point predictor.
// ----------------------------------------------------------------------------
module tb;
    import slogev_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    slogev_req_t request;
    logic        cfg_wen;
    logic [6:0]  cfg_wdata;
    logic        done;
    slogev_rsp_t result;

    slater_orbital_grid_evaluator_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .request   (request),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata),
        .done      (done),
        .result    (result)
    );

    logic signed [31:0] atom_x [MAX_ATOMS];
    logic signed [31:0] atom_y [MAX_ATOMS];
    logic signed [31:0] atom_z [MAX_ATOMS];
    logic signed [31:0] basis_coef [MAX_BASIS];
    logic [23:0]        basis_zeta [MAX_BASIS];
    logic [2:0]         basis_kind [MAX_BASIS];
    logic [2:0]         basis_n [MAX_BASIS];
    logic [5:0]         basis_atom [MAX_BASIS];
    logic [6:0]         basis_count;

    slogev_rsp_t pending_results [$];
    int errors;
    int sent_items;
    int eval_count;
    int load_count;
    int sat_count;

    initial clk = 1'b0;
    always #5 clk = ~clk;

    initial
    begin
        #20_000_000;
        $display("tb: done, errors");
        $finish;
    end

    function automatic logic [63:0] scale_clip(input logic [63:0] m, input logic [63:0] b,
                                               input int sh, inout bit clip);
        logic [127:0] prod;
        prod = m * b;
        prod = prod >> sh;
        if (prod > TERM_LIM)
        begin
            clip = 1'b1;
            return 64'(TERM_LIM);
        end
        return prod[63:0];
    endfunction

    function automatic logic [63:0] int_root(input logic [65:0] rad);
        logic [69:0] root;
        logic [69:0] rem;
        logic [69:0] trial;
        root = '0;
        rem  = '0;
        for (int i = 32; i >= 0; i--)
        begin
            rem   = (rem << 2) | 70'(rad[2*i +: 2]);
            trial = (root << 2) | 70'd1;
            if (rem >= trial)
            begin
                rem  = rem - trial;
                root = (root << 1) | 70'd1;
            end
            else
                root = root << 1;
        end
        return root[63:0];
    endfunction

    function automatic logic [63:0] decay_q30(input logic [63:0] t);
        logic [63:0] y;
        logic [63:0] k;
        logic [63:0] f;
        logic [63:0] g;
        logic [63:0] p;
        if (t >= (64'd64 << FRAC_BITS))
            return 64'd0;
        y = (t * 64'(LOG2E_Q30)) >> 30;
        k = y >> FRAC_BITS;
        if (k >= 30)
            return 64'd0;
        f = (y & ((64'd1 << FRAC_BITS) - 1)) << (30 - FRAC_BITS);
        g = (f * 64'(LN2_Q30)) >> 30;
        p = 64'(Q30_ONE);
        for (int i = 10; i >= 1; i--)
            p = 64'(Q30_ONE) - ((g * p) >> 30) / 64'(i);
        return p >> k;
    endfunction

    function automatic slogev_rsp_t orbital_at(input logic signed [31:0] px,
                                               input logic signed [31:0] py,
                                               input logic signed [31:0] pz);
        slogev_rsp_t rsp;
        longint      acc;
        longint      d [3];
        longint      coef;
        longint      comp;
        logic [63:0] a0;
        logic [63:0] a1;
        logic [63:0] a2;
        logic [65:0] rad;
        logic [63:0] r;
        logic [63:0] m;
        logic [63:0] zr;
        int          cnt;
        int          pw;
        bit          neg;
        bit          clip;
        logic [5:0]  c;
        acc  = 0;
        clip = 1'b0;
        cnt  = (basis_count > MAX_BASIS) ? MAX_BASIS : int'(basis_count);
        for (int b = 0; b < cnt; b++)
        begin
            if (basis_kind[b] > KIND_PZ)
                continue;
            c    = basis_atom[b];
            d[0] = longint'(px) - longint'(atom_x[c]);
            d[1] = longint'(py) - longint'(atom_y[c]);
            d[2] = longint'(pz) - longint'(atom_z[c]);
            a0   = (d[0] < 0) ? -d[0] : d[0];
            a1   = (d[1] < 0) ? -d[1] : d[1];
            a2   = (d[2] < 0) ? -d[2] : d[2];
            rad  = 66'(a0) * 66'(a0) + 66'(a1) * 66'(a1) + 66'(a2) * 66'(a2);
            r    = int_root(rad);
            coef = longint'(basis_coef[b]);
            neg  = coef < 0;
            zr   = (64'(basis_zeta[b]) * r) >> FRAC_BITS;
            m    = scale_clip((coef < 0) ? -coef : coef, decay_q30(zr), 30, clip);
            pw   = (basis_kind[b] == KIND_S) ? int'(basis_n[b]) - 1 : int'(basis_n[b]) - 2;
            for (int j = 0; j < pw; j++)
                m = scale_clip(m, r, FRAC_BITS, clip);
            if (basis_kind[b] != KIND_S)
            begin
                comp = d[basis_kind[b] - 1];
                if (comp < 0)
                    neg = !neg;
                m = scale_clip(m, (comp < 0) ? -comp : comp, FRAC_BITS, clip);
            end
            acc += neg ? -longint'(m) : longint'(m);
        end
        if (acc > 64'sd2147483647)
        begin
            acc  = 64'sd2147483647;
            clip = 1'b1;
        end
        else if (acc < -64'sd2147483648)
        begin
            acc  = -64'sd2147483648;
            clip = 1'b1;
        end
        rsp.orbital_value = acc[31:0];
        rsp.is_value      = 1'b1;
        rsp.saturated     = clip;
        return rsp;
    endfunction

    function automatic slogev_rsp_t apply_request(input slogev_req_t rq);
        slogev_rsp_t rsp;
        rsp = '0;
        case (rq.req_type)
            REQ_ATOM:
            begin
                atom_x[rq.entry_index] = rq.coord_x;
                atom_y[rq.entry_index] = rq.coord_y;
                atom_z[rq.entry_index] = rq.coord_z;
            end
            REQ_BASIS:
            begin
                basis_coef[rq.entry_index] = rq.coefficient;
                basis_zeta[rq.entry_index] = rq.exponent;
                basis_kind[rq.entry_index] = rq.orbital_kind;
                basis_n[rq.entry_index]    = rq.principal_number;
                basis_atom[rq.entry_index] = rq.centre_atom;
            end
            REQ_EVAL:
                rsp = orbital_at(rq.coord_x, rq.coord_y, rq.coord_z);
            default:
                rsp = '0;
        endcase
        return rsp;
    endfunction

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("tb: mismatch %s got %h want %h at %0t", what, got, want, $time);
        errors++;
    endtask

    always @(posedge clk)
    begin
        slogev_rsp_t want;
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
                report("unexpected transfer", 32'(result), 32'd0);
            else
            begin
                want = pending_results.pop_front();
                if (result.orbital_value !== want.orbital_value)
                    report("orbital_value", result.orbital_value, want.orbital_value);
                if (result.is_value !== want.is_value)
                    report("is_value", 32'(result.is_value), 32'(want.is_value));
                if (result.saturated !== want.saturated)
                    report("saturated", 32'(result.saturated), 32'(want.saturated));
                if (want.saturated)
                    sat_count++;
            end
        end
    end

    // call at a falling edge; returns at the falling edge after the transfer
    task automatic send(input slogev_req_t rq);
        start   = 1'b1;
        request = rq;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        pending_results = {pending_results, apply_request(rq)};
        sent_items++;
        if (rq.req_type == REQ_EVAL)
            eval_count++;
        else
            load_count++;
        @(negedge clk);
        start = 1'b0;
    endtask

    task automatic drain();
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (100) @(negedge clk);
    endtask

    task automatic write_count(input logic [6:0] value);
        drain();
        cfg_wen   = 1'b1;
        cfg_wdata = value;
        @(negedge clk);
        cfg_wen     = 1'b0;
        basis_count = value;
    endtask

    function automatic logic signed [31:0] near_coord();
        return $signed($urandom_range(0, 12 << 16)) - (6 << 16);
    endfunction

    function automatic slogev_req_t any_request();
        slogev_req_t  rq;
        logic [191:0] raw;
        raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        rq  = raw[$bits(slogev_req_t)-1:0];
        return rq;
    endfunction

    function automatic slogev_req_t atom_load(input logic [5:0] slot);
        slogev_req_t rq;
        rq             = any_request();
        rq.req_type    = REQ_ATOM;
        rq.entry_index = slot;
        rq.coord_x     = near_coord();
        rq.coord_y     = near_coord();
        rq.coord_z     = near_coord();
        return rq;
    endfunction

    function automatic slogev_req_t basis_load(input logic [5:0] slot);
        slogev_req_t rq;
        rq                  = any_request();
        rq.req_type         = REQ_BASIS;
        rq.entry_index      = slot;
        rq.coefficient      = $signed($urandom_range(0, 8 << 16)) - (4 << 16);
        rq.exponent         = 24'($urandom_range(1 << 13, 3 << 16));
        rq.orbital_kind     = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(4, 7))
                                                          : 3'($urandom_range(0, 3));
        rq.principal_number = 3'($urandom_range(1, 7));
        return rq;
    endfunction

    function automatic slogev_req_t point_eval();
        slogev_req_t rq;
        logic [5:0]  c;
        rq          = any_request();
        rq.req_type = REQ_EVAL;
        c           = 6'($urandom);
        if ($urandom_range(0, 7) == 0)
        begin
            rq.coord_x = atom_x[c];
            rq.coord_y = atom_y[c];
            rq.coord_z = atom_z[c];
        end
        else
        begin
            rq.coord_x = near_coord();
            rq.coord_y = near_coord();
            rq.coord_z = near_coord();
        end
        return rq;
    endfunction

    task automatic test_table_fill();
        for (int i = 0; i < MAX_ATOMS; i++)
            send(atom_load(6'(i)));
        for (int i = 0; i < MAX_BASIS; i++)
            send(basis_load(6'(i)));
    endtask

    task automatic test_directed();
        slogev_req_t rq;
        write_count(7'd0);
        send(point_eval());
        rq          = '0;
        rq.req_type = REQ_NOP;
        send(rq);
        send(~rq);
        write_count(7'd127);
        send(point_eval());
        write_count(7'd1);
        // a point on the centre atom: r is zero
        rq            = basis_load(6'd0);
        rq.orbital_kind = KIND_S;
        rq.principal_number = 3'd1;
        rq.centre_atom = 6'd5;
        send(rq);
        rq          = point_eval();
        rq.coord_x  = atom_x[5];
        rq.coord_y  = atom_y[5];
        rq.coord_z  = atom_z[5];
        send(rq);
        for (int k = 0; k < 8; k++)
        begin
            rq                  = basis_load(6'd0);
            rq.orbital_kind     = 3'(k);
            rq.principal_number = 3'(k);
            send(rq);
            send(point_eval());
        end
        // huge coefficient, no decay, far point: every clip path
        rq                  = basis_load(6'd0);
        rq.coefficient      = 32'sh8000_0000;
        rq.exponent         = 24'd0;
        rq.orbital_kind     = KIND_PX;
        rq.principal_number = 3'd7;
        rq.centre_atom      = 6'd0;
        send(atom_load(6'd0));
        send(rq);
        rq          = point_eval();
        rq.coord_x  = 32'sh7fff_ffff;
        rq.coord_y  = 32'sh8000_0000;
        rq.coord_z  = 32'sh7fff_ffff;
        send(rq);
        rq.coefficient = 32'sh7fff_ffff;
        rq.req_type    = REQ_BASIS;
        rq.exponent    = 24'hff_ffff;
        send(rq);
        rq.req_type = REQ_EVAL;
        send(rq);
        write_count(7'd64);
        send(point_eval());
    endtask

    task automatic test_random();
        int          burst;
        int          pick;
        logic [6:0]  counts [5];
        slogev_req_t rq;
        counts = '{7'd0, 7'd1, 7'd64, 7'd127, 7'd8};
        while (sent_items < 1250)
        begin
            if ($urandom_range(0, 199) == 0)
                write_count(($urandom_range(0, 1) == 0) ? counts[$urandom_range(0, 4)]
                                                        : 7'($urandom_range(0, 40)));
            burst = $urandom_range(1, 16);
            repeat (burst)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 10)
                    rq = any_request();
                else if (pick < 35)
                    rq = atom_load(6'($urandom));
                else if (pick < 60)
                    rq = basis_load(6'($urandom));
                else
                    rq = point_eval();
                send(rq);
            end
            if ($urandom_range(0, 3) != 0)
                repeat ($urandom_range(1, 20)) @(negedge clk);
        end
    endtask

    initial
    begin
        rst_n       = 1'b0;
        start       = 1'b0;
        request     = '0;
        cfg_wen     = 1'b0;
        cfg_wdata   = '0;
        basis_count = '0;
        errors      = 0;
        sent_items  = 0;
        eval_count  = 0;
        load_count  = 0;
        sat_count   = 0;
        repeat (11) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        test_table_fill();
        test_directed();
        test_random();
        drain();
        $display("tb: %0d transfers in (%0d evaluations, %0d loads or no-ops)",
                 sent_items, eval_count, load_count);
        $display("tb: %0d saturated results seen", sat_count);
        if (errors == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/slogev_pkg.sv
hw/rtl/slogev_ram.sv
hw/rtl/slogev_term.sv
hw/rtl/slater_orbital_grid_evaluator_unit.sv
sim/tb.sv
